// File: rtl/core/edge_table_add_wins_merge_assert.svh
// Assertion macros for the edge table block.
// Used by the top level; needs clk_i and rst_ni in scope.
`ifndef EDGE_TABLE_ADD_WINS_MERGE_ASSERT_SVH
`define EDGE_TABLE_ADD_WINS_MERGE_ASSERT_SVH
// Same-cycle implication, reset masked.
`define ETAWM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("etawm check failed");
// Next-cycle implication, reset masked.
`define ETAWM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("etawm check failed");
`endif

// File: rtl/core/etawm_pkg.sv
// Shared types and constants of the edge table block.
// No dependencies.
`default_nettype none
package etawm_pkg;
  localparam int TABLE_ROWS  = 32;
  localparam int MAX_RESULTS = 32;
  localparam int IDX_W = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
  localparam int CNT_W = $clog2(TABLE_ROWS + 1);

  localparam logic [1:0] CMD_ASSERT  = 2'd0;
  localparam logic [1:0] CMD_LOOKUP  = 2'd1;
  localparam logic [1:0] CMD_MEMBERS = 2'd2;
  localparam logic [1:0] CMD_PARENTS = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SELF  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_STALE = 2'd3;

  // One stored edge.
  typedef struct packed {
    logic [63:0] parent;
    logic [63:0] child;
    logic [63:0] issuer;
    logic [63:0] sequence_n;
    logic        present;
  } entry_t;

  // Compare flags of a cell against the current key.
  typedef struct packed {
    logic parent_eq;
    logic child_eq;
  } hit_t;
endpackage
`default_nettype wire

// File: rtl/core/etawm_cell.sv
// One table row of the rotating edge ring, with its key comparators.
// Depends on etawm_pkg.
`default_nettype none
module etawm_cell import etawm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        shift_i,
  input  wire entry_t      prev_i,
  input  wire logic [63:0] parent_i,
  input  wire logic [63:0] child_i,
  output entry_t           entry_o,
  output hit_t             hit_o
);
  entry_t entry_q;

  // Take the neighbor's row on each ring step.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= prev_i;
    end
  end

  // Key compare of the held row.
  assign hit_o.parent_eq = (entry_q.parent == parent_i);
  assign hit_o.child_eq  = (entry_q.child == child_i);
  assign entry_o = entry_q;
endmodule
`default_nettype wire

// File: rtl/core/edge_table_add_wins_merge.sv
// Edge table with add-wins merge: a ring of row cells that rotates once per item.
// Items enter on in_valid_i/in_stall_o; results leave on out_valid_o/out_stall_i.
// An item is taken only when the block is idle. Its work is one full turn of
// the ring, with row k at the head cell in step k, followed by a closing step
// for the result. Assert, lookup and empty listings give one result; a listing
// gives one result per matching present id, in insertion order, up to its cap,
// with last set on the final one. Each listing id is held back until the next
// match or the end of the turn, so that the final one can carry last.
// The ring stops while a result waits and out_stall_i is high, so no result
// is lost. Reset clears the row count and control state; row contents are not
// cleared, as only rows below the count are ever read.
// Depends on etawm_pkg, etawm_cell and edge_table_add_wins_merge_assert.svh.
`default_nettype none
module edge_table_add_wins_merge import etawm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [63:0] parent_id_i,
  input  wire logic [63:0] child_id_i,
  input  wire logic [63:0] issuer_key_i,
  input  wire logic [63:0] sequence_req_i,
  input  wire logic        link_flag_i,
  input  wire logic [5:0]  list_cap_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic             found_o,
  output logic             held_present_o,
  output logic [63:0]      held_issuer_o,
  output logic [63:0]      held_sequence_o,
  output logic [63:0]      listed_id_o,
  output logic             last_o
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [1:0]       cmd_q;
  logic [63:0]      parent_q, child_q, issuer_q, seq_q;
  logic             link_q;
  logic [5:0]       cap_q;
  logic [IDX_W-1:0] step_q;
  logic [CNT_W-1:0] rows_used_q;
  logic             hit_q, app_q;
  logic [1:0]       status_q;
  logic             hpres_q;
  logic [63:0]      hiss_q, hseq_q;
  logic             pend_q;
  logic [63:0]      pend_id_q;
  logic [5:0]       n_q;

  logic             ov_q, of_q, ohp_q, olast_q;
  logic [1:0]       ost_q;
  logic [63:0]      ohi_q, ohs_q, oid_q;

  entry_t           ring [TABLE_ROWS];
  hit_t             hits [TABLE_ROWS];
  entry_t           tail_d;
  logic             adv, accept, shift, row_ok, match, last_step;
  logic             wins, self_edge, lmatch;
  logic             emit;
  logic [63:0]      lid;

  assign accept = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign adv = !ov_q || !out_stall_i;
  assign shift = (state_q == S_SCAN) && adv;

  // The ring of row cells; the head row's write-back enters at the tail.
  for (genvar j = 0; j < TABLE_ROWS; j++) begin : g_cell
    entry_t prev;
    if (j == TABLE_ROWS - 1) begin : g_tail
      assign prev = tail_d;
    end else begin : g_mid
      assign prev = ring[j+1];
    end
    etawm_cell u_cell (
      .clk_i    (clk_i),
      .shift_i  (shift),
      .prev_i   (prev),
      .parent_i (parent_q),
      .child_i  (child_q),
      .entry_o  (ring[j]),
      .hit_o    (hits[j])
    );
  end

  // Head row decode and merge decision.
  always_comb begin
    row_ok    = (CNT_W'(step_q) < rows_used_q);
    match     = row_ok && hits[0].parent_eq && hits[0].child_eq;
    last_step = (step_q == IDX_W'(TABLE_ROWS - 1));
    self_edge = (parent_q == child_q);
    if (ring[0].issuer == issuer_q) begin
      wins = (seq_q > ring[0].sequence_n);
    end else begin
      wins = link_q && !ring[0].present;
    end
    lmatch = row_ok && ring[0].present && (n_q < cap_q) &&
             ((cmd_q == CMD_MEMBERS) ? hits[0].parent_eq : hits[0].child_eq);
    lid = (cmd_q == CMD_MEMBERS) ? ring[0].child : ring[0].parent;
    tail_d = ring[0];
    if (cmd_q == CMD_ASSERT && !self_edge) begin
      if (match && wins) begin
        tail_d.issuer     = issuer_q;
        tail_d.sequence_n = seq_q;
        tail_d.present    = link_q;
      end else if (!hit_q && CNT_W'(step_q) == rows_used_q) begin
        tail_d.parent     = parent_q;
        tail_d.child      = child_q;
        tail_d.issuer     = issuer_q;
        tail_d.sequence_n = seq_q;
        tail_d.present    = link_q;
      end
    end
    emit = (cmd_q == CMD_MEMBERS || cmd_q == CMD_PARENTS) && lmatch && pend_q;
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_SCAN;
      S_SCAN:  if (adv && last_step) state_d = S_DONE;
      S_DONE:  if (adv) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rows_used_q <= '0;
      ov_q        <= 1'b0;
      step_q      <= '0;
      hit_q       <= 1'b0;
      app_q       <= 1'b0;
      pend_q      <= 1'b0;
      n_q         <= '0;
      status_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      // A result is loaded on a listing emit or at the closing step.
      if ((shift && emit) || (state_q == S_DONE && adv)) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
      if (accept) begin
        step_q   <= '0;
        hit_q    <= 1'b0;
        app_q    <= 1'b0;
        pend_q   <= 1'b0;
        n_q      <= '0;
        status_q <= (command_i == CMD_ASSERT && parent_id_i == child_id_i) ? ST_SELF : ST_OK;
      end else if (shift) begin
        step_q <= step_q + 1'b1;
        if (match) begin
          hit_q <= 1'b1;
        end
        if (cmd_q == CMD_ASSERT && !self_edge) begin
          if (match && !wins) begin
            status_q <= ST_STALE;
          end else if (!match && !hit_q && CNT_W'(step_q) == rows_used_q) begin
            app_q <= 1'b1;
          end
        end
        if ((cmd_q == CMD_MEMBERS || cmd_q == CMD_PARENTS) && lmatch) begin
          pend_q <= 1'b1;
          n_q    <= n_q + 1'b1;
        end
      end else if (state_q == S_DONE && adv) begin
        if (app_q) begin
          rows_used_q <= rows_used_q + 1'b1;
        end
        if (cmd_q == CMD_ASSERT && !self_edge && !hit_q && rows_used_q == CNT_W'(TABLE_ROWS)) begin
          status_q <= ST_FULL;
        end
      end
    end
  end

  // Item payload, lookup capture and result register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= command_i;
      parent_q <= parent_id_i;
      child_q  <= child_id_i;
      issuer_q <= issuer_key_i;
      seq_q    <= sequence_req_i;
      link_q   <= link_flag_i;
      cap_q    <= (list_cap_i > 6'(MAX_RESULTS)) ? 6'(MAX_RESULTS) : list_cap_i;
      hpres_q  <= 1'b0;
      hiss_q   <= '0;
      hseq_q   <= '0;
    end else if (shift) begin
      if (match && cmd_q == CMD_LOOKUP) begin
        hpres_q <= ring[0].present;
        hiss_q  <= ring[0].issuer;
        hseq_q  <= ring[0].sequence_n;
      end
      if ((cmd_q == CMD_MEMBERS || cmd_q == CMD_PARENTS) && lmatch) begin
        pend_id_q <= lid;
      end
      if (emit) begin
        ost_q   <= ST_OK;
        of_q    <= 1'b1;
        ohp_q   <= 1'b0;
        ohi_q   <= '0;
        ohs_q   <= '0;
        oid_q   <= pend_id_q;
        olast_q <= 1'b0;
      end
    end else if (state_q == S_DONE && adv) begin
      // Lookup fields stay zero for other commands; the pending id only for listings.
      olast_q <= 1'b1;
      ohp_q   <= hpres_q;
      ohi_q   <= hiss_q;
      ohs_q   <= hseq_q;
      oid_q   <= pend_q ? pend_id_q : '0;
      case (cmd_q)
        CMD_ASSERT: begin
          of_q  <= 1'b0;
          ost_q <= (!self_edge && !hit_q && rows_used_q == CNT_W'(TABLE_ROWS)) ?
                   ST_FULL : status_q;
        end
        CMD_LOOKUP: begin
          of_q  <= hit_q;
          ost_q <= ST_OK;
        end
        default: begin
          of_q  <= pend_q;
          ost_q <= ST_OK;
        end
      endcase
    end
  end

  assign out_valid_o     = ov_q;
  assign status_o        = ost_q;
  assign found_o         = of_q;
  assign held_present_o  = ohp_q;
  assign held_issuer_o   = ohi_q;
  assign held_sequence_o = ohs_q;
  assign listed_id_o     = oid_q;
  assign last_o          = olast_q;

`include "edge_table_add_wins_merge_assert.svh"
  `ETAWM_ASSERT_NOW(a_rows_bound, 1'b1, rows_used_q <= CNT_W'(TABLE_ROWS))
  `ETAWM_ASSERT_NEXT(a_accept_scan, accept, state_q == S_SCAN && step_q == '0)
  `ETAWM_ASSERT_NEXT(a_done_last, state_q == S_DONE && adv, ov_q && olast_q)
endmodule
`default_nettype wire

// File: verif/tb_top.sv
// Testbench for the edge table with add-wins merge: random and directed commands
// checked result by result against a behavioral table kept in the scoreboard.
// Depends on etawm_pkg and the edge_table_add_wins_merge RTL.
`timescale 1ns / 100ps
`default_nettype none

// Scoreboard: keeps its own edge table and a queue of expected results.
class edge_table_scoreboard;
  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic        present;
    logic [63:0] issuer;
    logic [63:0] seq;
    logic [63:0] id;
    logic        last;
  } edge_result_t;

  logic [63:0] row_parent [etawm_pkg::TABLE_ROWS];
  logic [63:0] row_child  [etawm_pkg::TABLE_ROWS];
  logic [63:0] row_issuer [etawm_pkg::TABLE_ROWS];
  logic [63:0] row_seq    [etawm_pkg::TABLE_ROWS];
  logic        row_present[etawm_pkg::TABLE_ROWS];
  int          rows_held;
  edge_result_t pending[$];
  int          errors;
  int          results_seen;

  function new();
    rows_held = 0;
    errors = 0;
    results_seen = 0;
  endfunction

  function int find_row(logic [63:0] p, logic [63:0] c);
    for (int i = 0; i < rows_held; i++)
      if (row_parent[i] == p && row_child[i] == c) return i;
    return -1;
  endfunction

  function edge_result_t blank();
    edge_result_t r;
    r = '0;
    r.status = etawm_pkg::ST_OK;
    r.last = 1'b1;
    return r;
  endfunction

  // Applies one accepted item to the table and queues what it should produce.
  function void note_item(logic [1:0] cmd, logic [63:0] p, logic [63:0] c,
                          logic [63:0] iss, logic [63:0] sq, logic lnk, logic [5:0] cap_in);
    edge_result_t r;
    int row;
    int cap;
    int n;
    r = blank();
    if (cmd == etawm_pkg::CMD_ASSERT) begin
      if (p == c) begin
        r.status = etawm_pkg::ST_SELF;
      end else begin
        row = find_row(p, c);
        if (row >= 0) begin
          if ((row_issuer[row] == iss) ? (sq > row_seq[row])
              : (row_present[row] != lnk && lnk)) begin
            row_issuer[row] = iss;
            row_seq[row] = sq;
            row_present[row] = lnk;
          end else begin
            r.status = etawm_pkg::ST_STALE;
          end
        end else if (rows_held >= etawm_pkg::TABLE_ROWS) begin
          r.status = etawm_pkg::ST_FULL;
        end else begin
          row_parent[rows_held] = p;
          row_child[rows_held] = c;
          row_issuer[rows_held] = iss;
          row_seq[rows_held] = sq;
          row_present[rows_held] = lnk;
          rows_held++;
        end
      end
      pending.push_back(r);
    end else if (cmd == etawm_pkg::CMD_LOOKUP) begin
      row = find_row(p, c);
      if (row >= 0) begin
        r.found = 1'b1;
        r.present = row_present[row];
        r.issuer = row_issuer[row];
        r.seq = row_seq[row];
      end
      pending.push_back(r);
    end else begin
      cap = (cap_in > etawm_pkg::MAX_RESULTS) ? etawm_pkg::MAX_RESULTS : cap_in;
      n = 0;
      for (int i = 0; i < rows_held && n < cap; i++) begin
        if (!row_present[i]) continue;
        if (cmd == etawm_pkg::CMD_MEMBERS ? row_parent[i] != p : row_child[i] != c) continue;
        r = blank();
        r.found = 1'b1;
        r.last = 1'b0;
        r.id = (cmd == etawm_pkg::CMD_MEMBERS) ? row_child[i] : row_parent[i];
        pending.push_back(r);
        n++;
      end
      if (n == 0) pending.push_back(blank());
      else pending[$].last = 1'b1;
    end
  endfunction

  task report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch: %s got %h expected %h (result %0d)", what, got, want, results_seen);
  endtask

  // Compares one accepted result with the oldest expectation.
  task check_result(edge_result_t got);
    edge_result_t want;
    results_seen++;
    if (pending.size() == 0) begin
      report("unexpected result", got.id, 0);
      return;
    end
    want = pending.pop_front();
    if (got.status !== want.status) report("status", got.status, want.status);
    if (got.found !== want.found) report("found", got.found, want.found);
    if (got.present !== want.present) report("held_present", got.present, want.present);
    if (got.issuer !== want.issuer) report("held_issuer", got.issuer, want.issuer);
    if (got.seq !== want.seq) report("held_sequence", got.seq, want.seq);
    if (got.id !== want.id) report("listed_id", got.id, want.id);
    if (got.last !== want.last) report("last", got.last, want.last);
  endtask
endclass

module tb_top;
  import etawm_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  command_i = CMD_LOOKUP;
  logic [63:0] parent_id_i = '0;
  logic [63:0] child_id_i = '0;
  logic [63:0] issuer_key_i = '0;
  logic [63:0] sequence_req_i = '0;
  logic        link_flag_i = 1'b0;
  logic [5:0]  list_cap_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic        found_o;
  logic        held_present_o;
  logic [63:0] held_issuer_o;
  logic [63:0] held_sequence_o;
  logic [63:0] listed_id_o;
  logic        last_o;

  edge_table_scoreboard board = new();
  int items_sent = 0;
  int idle_cycles = 0;
  logic [63:0] id_pool[8];
  logic [63:0] issuer_pool[3];

  edge_table_add_wins_merge dut (.*);

  // Clock: 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Result side: check at accept edges, stall on a pattern of its own.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        board.check_result({status_o, found_o, held_present_o, held_issuer_o,
                            held_sequence_o, listed_id_o, last_o});
      case ($urandom_range(0, 3))
        0: out_stall_i <= ($urandom_range(0, 1) == 0);
        1: out_stall_i <= ($urandom_range(0, 5) == 0);
        default: out_stall_i <= (items_sent % 60 < 20) ? 1'b0 : out_stall_i;
      endcase
    end
  end

  // Watchdog: counts cycles without any accepted item or result.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("== FAIL ==");
      $finish;
    end
  end

  // Drives one item and holds it until the block accepts it.
  task automatic send_item(logic [1:0] cmd, logic [63:0] p, logic [63:0] c,
                           logic [63:0] iss, logic [63:0] sq, logic lnk, logic [5:0] cap);
    in_valid_i <= 1'b1;
    command_i <= cmd;
    parent_id_i <= p;
    child_id_i <= c;
    issuer_key_i <= iss;
    sequence_req_i <= sq;
    link_flag_i <= lnk;
    list_cap_i <= cap;
    do @(posedge clk_i); while (in_stall_o);
    board.note_item(cmd, p, c, iss, sq, lnk, cap);
    items_sent++;
  endtask

  task automatic pause_sender(int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Waits until every expected result has been checked.
  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random();
    logic [1:0] cmd;
    logic [63:0] p, c;
    cmd = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 9) == 0) begin
      p = {$urandom, $urandom};
      c = {$urandom, $urandom};
    end else begin
      p = id_pool[$urandom_range(0, 7)];
      c = id_pool[$urandom_range(0, 7)];
    end
    send_item(cmd, p, c, issuer_pool[$urandom_range(0, 2)],
              ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'($urandom_range(0, 6)),
              1'($urandom), 6'($urandom_range(0, 63)));
  endtask

  initial begin
    logic [63:0] ones;
    ones = '1;
    for (int i = 0; i < 8; i++) id_pool[i] = (i < 2) ? (i == 0 ? 64'd0 : ones) : {$urandom, $urandom};
    issuer_pool[0] = 64'd0;
    issuer_pool[1] = ones;
    issuer_pool[2] = {$urandom, $urandom};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: self edge, append, lookups, merge rules, tombstone, listings.
    send_item(CMD_ASSERT, ones, ones, 0, 0, 1'b1, 0);
    send_item(CMD_LOOKUP, 1, 2, 0, 0, 0, 0);
    send_item(CMD_MEMBERS, 1, 0, 0, 0, 0, 5);
    send_item(CMD_ASSERT, 0, ones, ones, ones, 1'b1, 0);
    send_item(CMD_ASSERT, 0, ones, ones, ones, 1'b0, 0);
    send_item(CMD_ASSERT, 0, ones, ones, 5, 1'b0, 0);
    send_item(CMD_ASSERT, 0, 7, 1, 3, 1'b0, 0);
    send_item(CMD_ASSERT, 0, 7, 2, 1, 1'b0, 0);
    send_item(CMD_ASSERT, 0, 7, 2, 0, 1'b1, 0);
    send_item(CMD_ASSERT, 0, 7, 1, 9, 1'b1, 0);
    send_item(CMD_ASSERT, 0, 7, 2, 9, 1'b0, 0);
    send_item(CMD_ASSERT, 0, 7, 2, 10, 1'b0, 0);
    send_item(CMD_LOOKUP, 0, ones, 0, 0, 0, 0);
    send_item(CMD_LOOKUP, 0, 7, 0, 0, 0, 0);
    send_item(CMD_ASSERT, 9, 7, 4, 4, 1'b1, 0);
    send_item(CMD_MEMBERS, 0, 0, 0, 0, 0, 63);
    send_item(CMD_MEMBERS, 0, 0, 0, 0, 0, 0);
    send_item(CMD_PARENTS, 0, 7, 0, 0, 0, 1);
    send_item(CMD_PARENTS, 0, 7, 0, 0, 0, 32);
    pause_sender(1);
    drain();

    // Fill the table to its limit, then show the full status and long listings.
    for (int i = board.rows_held; i < TABLE_ROWS; i++)
      send_item(CMD_ASSERT, 64'd5, 64'(100 + i), 3, 1, 1'($urandom_range(0, 3) != 0), 0);
    send_item(CMD_ASSERT, 64'd5, 64'd99, 3, 1, 1'b1, 0);
    send_item(CMD_MEMBERS, 64'd5, 0, 0, 0, 0, 63);
    send_item(CMD_MEMBERS, 64'd5, 0, 0, 0, 0, 33);
    pause_sender(1);
    drain();

    // Random part in bursts; the table is full, so asserts exercise the merge rule.
    while (items_sent < 180) begin
      repeat ($urandom_range(1, 12)) send_random();
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 40));
    end
    in_valid_i <= 1'b0;

    drain();
    repeat (80) @(posedge clk_i);
    $display("Ran %0d items and checked %0d results, including self edges, merges,",
             items_sent, board.results_seen);
    $display("tombstones, a full table and capped listings.");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

`default_nettype wire
